[rtl/tfb_pkg.sv]
// Shared types, constants and functions of the TLV frame builder.
// No dependencies; every module imports this package.
package tfb_pkg;

  localparam int ID_LEN_DEF    = 8;
  localparam int TIME_LEN_DEF  = 20;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_MSB      = 16'h8000;
  localparam logic [15:0] HEADER_RESET = 16'h0000;
  localparam logic [7:0]  TAG_RESET    = 8'h01;
  localparam logic [15:0] POLY_RESET   = 16'h1021;

  localparam logic MODE_TEXT = 1'b0;
  localparam logic MODE_TEMP = 1'b1;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x up to 32768
  localparam logic [15:0] RECIP_100   = 16'd41944;
  localparam int          RECIP_SHIFT = 22;

  typedef enum logic [1:0] {
    REG_HEADER = 2'd0,
    REG_TAG    = 2'd1,
    REG_POLY   = 2'd2
  } reg_index_t;

  typedef enum logic [7:0] {
    PH_NEW  = 8'b0000_0001,
    PH_HDR  = 8'b0000_0010,
    PH_STR  = 8'b0000_0100,
    PH_PAD  = 8'b0000_1000,
    PH_INT  = 8'b0001_0000,
    PH_FRAC = 8'b0010_0000,
    PH_CRCL = 8'b0100_0000,
    PH_CRCH = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic [7:0]  tag_value;
    logic [15:0] crc_polynomial;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  text_byte;
    logic        neg;
    logic [15:0] mag;
    logic [8:0]  quo;
  } item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/tfb_if.sv]
// Word channels of the TLV frame builder: input items and frame bytes.
// Depends on nothing.
interface tfb_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [7:0]         text_byte;
  logic signed [15:0] temp_centi;

  modport source (output valid, output mode, output text_byte, output temp_centi,
                  input ready);
  modport sink   (input valid, input mode, input text_byte, input temp_centi,
                  output ready);
endinterface

interface tfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface

[rtl/tlv_frame_builder_crc16.sv]
// Top level of the TLV frame builder with CRC-16: configuration registers,
// input stage and byte sequencer. Depends on tfb_pkg, tfb_if, tfb_in_stage,
// tfb_emitter.
//
//   channel  role   payload
//   item     sink   mode, text_byte, temp_centi
//   frame    source out_byte, run_last, frame_end
//   cfg_*    write  cfg_index selects header_word, tag_value, crc_polynomial
//
// One byte leaves per cycle while the frame sink is ready. A string item
// emits at most one byte; a temperature item emits a pad byte per missing
// string byte, integer, fraction and two CRC bytes. The five header bytes
// come first when an item opens a frame. The output register lets the next
// item enter while a byte waits. Reset clears all control state at once.
module tlv_frame_builder_crc16
  import tfb_pkg::*;
#(
  parameter int ID_LEN         = ID_LEN_DEF,
  parameter int TIME_FIELD_LEN = TIME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tfb_in_if.sink      item,
  tfb_out_if.source   frame,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(ID_LEN + TIME_FIELD_LEN + 1);

  cfg_t          cfg;
  item_t         item_reg;
  logic          item_valid;
  logic          item_done;
  logic          frame_open;
  logic [CW-1:0] fill_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_word    <= HEADER_RESET;
      cfg.tag_value      <= TAG_RESET;
      cfg.crc_polynomial <= POLY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER: cfg.header_word    <= cfg_data;
        REG_TAG:    cfg.tag_value      <= cfg_data[7:0];
        REG_POLY:   cfg.crc_polynomial <= cfg_data;
        default: ;
      endcase
    end
  end

  tfb_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_done  (item_done),
    .item_valid (item_valid),
    .item_reg   (item_reg)
  );

  tfb_emitter #(
    .ID_LEN         (ID_LEN),
    .TIME_FIELD_LEN (TIME_FIELD_LEN)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item_reg),
    .item_valid (item_valid),
    .item_done  (item_done),
    .frame      (frame),
    .frame_open (frame_open),
    .fill_count (fill_count)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(ID_LEN + TIME_FIELD_LEN))
    else $error("string fill count beyond both fields");

  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    !frame_open |-> fill_count == '0)
    else $error("fill count left over with no frame open");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.frame_end |-> frame.run_last)
    else $error("frame end word not marked as last of its item");

  a_done_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_done |=> !frame_open || fill_count != '0 || !$past(frame.frame_end))
    else $error("frame closed with stale fill count");
`endif

endmodule

[rtl/tfb_in_stage.sv]
// Input register of the frame builder; splits the temperature into sign,
// magnitude and quotient by 100. Depends on tfb_pkg and tfb_in_if.
module tfb_in_stage
  import tfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tfb_in_if.sink     item,
  input  logic       item_done,
  output logic       item_valid,
  output item_t      item_reg
);

  logic        neg_in;
  logic [15:0] mag_in;
  logic [31:0] prod;

  assign item.ready = !item_valid || item_done;

  assign neg_in = item.temp_centi[15];
  assign mag_in = neg_in ? 16'(~item.temp_centi + 16'sd1) : 16'(item.temp_centi);
  assign prod   = 32'(mag_in) * 32'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item.ready) begin
      item_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_reg.mode      <= item.mode;
      item_reg.text_byte <= item.text_byte;
      item_reg.neg       <= neg_in;
      item_reg.mag       <= mag_in;
      item_reg.quo       <= prod[RECIP_SHIFT+8:RECIP_SHIFT];
    end
  end

endmodule

[rtl/tfb_emitter.sv]
// Byte sequencer of the frame builder: header, string fields, temperature and
// CRC, one byte a cycle while the output is free. Depends on tfb_pkg, tfb_out_if.
module tfb_emitter
  import tfb_pkg::*;
#(
  parameter int ID_LEN         = ID_LEN_DEF,
  parameter int TIME_FIELD_LEN = TIME_LEN_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  item_valid,
  output logic  item_done,
  tfb_out_if.source frame,
  output logic  frame_open,
  output logic [$clog2(ID_LEN+TIME_FIELD_LEN+1)-1:0] fill_count
);

  localparam int STR_TOTAL = ID_LEN + TIME_FIELD_LEN;
  localparam int CW        = $clog2(STR_TOTAL + 1);
  localparam logic [CW-1:0] TOTAL_C = CW'(STR_TOTAL);
  localparam logic [CW-1:0] LAST_C  = CW'(STR_TOTAL - 1);
  localparam logic [CW-1:0] ID_C    = CW'(ID_LEN);
  localparam logic [15:0]   LEN_C   = 16'(STR_TOTAL + 2);

  phase_t      phase, phase_eff, phase_next;
  logic [2:0]  hdr_cnt, hdr_cnt_next;
  logic        in_frame, in_frame_next;
  logic [CW-1:0] count, count_next;
  logic        zero_seen, zero_seen_next;
  logic [15:0] crc, crc_next;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_end;

  logic        advance;
  logic        emit, feed, step_done, fend;
  logic [7:0]  byte_val, hdr_byte, str_src, str_val;
  logic        zs_eff;
  logic [15:0] crc_fed;
  logic [15:0] qx, q100;
  logic [6:0]  rem;
  logic [8:0]  qneg;
  logic [7:0]  ip, fp;
  phase_t      post_hdr;

  assign advance = item_valid && (!out_valid || frame.ready);

  always_comb begin
    phase_eff = phase;
    unique case (phase)
      PH_NEW: begin
        if (!in_frame)           phase_eff = PH_HDR;
        else if (!item.mode)     phase_eff = PH_STR;
        else if (count < TOTAL_C) phase_eff = PH_PAD;
        else                     phase_eff = PH_INT;
      end
      PH_HDR, PH_STR, PH_PAD, PH_INT, PH_FRAC, PH_CRCL, PH_CRCH: phase_eff = phase;
      default: phase_eff = PH_NEW;
    endcase
  end

  always_comb begin
    case (hdr_cnt)
      3'd0:    hdr_byte = cfg.header_word[15:8];
      3'd1:    hdr_byte = cfg.header_word[7:0];
      3'd2:    hdr_byte = cfg.tag_value;
      3'd3:    hdr_byte = LEN_C[7:0];
      default: hdr_byte = LEN_C[15:8];
    endcase
  end

  assign str_src = item.mode ? 8'h00 : item.text_byte;
  assign zs_eff  = (count == ID_C) ? 1'b0 : zero_seen;
  assign str_val = zs_eff ? 8'h00 : str_src;

  assign qx   = {7'd0, item.quo};
  assign q100 = (qx << 6) + (qx << 5) + (qx << 2);
  assign rem  = 7'(item.mag - q100);
  assign qneg = 9'd0 - item.quo;
  assign ip   = item.neg ? qneg[7:0] : item.quo[7:0];
  assign fp   = item.neg ? 8'(8'd0 - {1'b0, rem}) : {1'b0, rem};

  assign post_hdr = item.mode ? PH_PAD : PH_STR;

  always_comb begin
    emit           = 1'b1;
    feed           = 1'b1;
    step_done      = 1'b0;
    fend           = 1'b0;
    byte_val       = 8'h00;
    phase_next     = phase_eff;
    hdr_cnt_next   = hdr_cnt;
    in_frame_next  = in_frame;
    count_next     = count;
    zero_seen_next = zero_seen;
    unique case (phase_eff)
      PH_HDR: begin
        byte_val     = hdr_byte;
        hdr_cnt_next = 3'(hdr_cnt + 3'd1);
        if (hdr_cnt == 3'd4) begin
          hdr_cnt_next  = 3'd0;
          in_frame_next = 1'b1;
          phase_next    = post_hdr;
        end
      end
      PH_STR: begin
        step_done  = 1'b1;
        phase_next = PH_NEW;
        if (count >= TOTAL_C) begin
          emit = 1'b0;
          feed = 1'b0;
        end else begin
          byte_val       = str_val;
          zero_seen_next = zs_eff || (str_val == 8'h00);
          count_next     = CW'(count + 1'b1);
        end
      end
      PH_PAD: begin
        byte_val       = str_val;
        zero_seen_next = 1'b1;
        count_next     = CW'(count + 1'b1);
        if (count == LAST_C) begin
          phase_next = PH_INT;
        end
      end
      PH_INT: begin
        byte_val   = ip;
        phase_next = PH_FRAC;
      end
      PH_FRAC: begin
        byte_val   = fp;
        phase_next = PH_CRCL;
      end
      PH_CRCL: begin
        byte_val   = crc[7:0];
        feed       = 1'b0;
        phase_next = PH_CRCH;
      end
      PH_CRCH: begin
        byte_val       = crc[15:8];
        feed           = 1'b0;
        fend           = 1'b1;
        step_done      = 1'b1;
        phase_next     = PH_NEW;
        in_frame_next  = 1'b0;
        count_next     = '0;
        zero_seen_next = 1'b0;
      end
      default: begin
        emit = 1'b0;
        feed = 1'b0;
      end
    endcase
  end

  assign crc_fed  = crc_byte(crc, byte_val, cfg.crc_polynomial);
  assign crc_next = fend ? CRC_INIT : (feed ? crc_fed : crc);

  assign item_done = advance && step_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NEW;
      hdr_cnt   <= 3'd0;
      in_frame  <= 1'b0;
      count     <= '0;
      zero_seen <= 1'b0;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        phase     <= phase_next;
        hdr_cnt   <= hdr_cnt_next;
        in_frame  <= in_frame_next;
        count     <= count_next;
        zero_seen <= zero_seen_next;
        crc       <= crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_byte <= byte_val;
      out_last <= step_done;
      out_end  <= fend;
    end
  end

  assign frame.valid     = out_valid;
  assign frame.out_byte  = out_byte;
  assign frame.run_last  = out_last;
  assign frame.frame_end = out_end;

  assign frame_open = in_frame;
  assign fill_count = count;

endmodule
